// ----- sv/lms_anc_pkg.sv -----
`default_nettype none

package lms_anc_pkg;

    localparam int DATA_W     = 16;
    localparam int WT_W       = 32;
    localparam int TAP_CNT_W  = 9;
    localparam int STEP_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int MPROD_W    = WT_W + DATA_W;
    localparam int MU_E_W     = STEP_W + 1 + DATA_W;
    localparam int UPROD_W    = MU_E_W + DATA_W;
    localparam int EST_SHIFT  = 28;
    localparam int UPD_SHIFT  = 26;
    localparam int DELTA_W    = UPROD_W - UPD_SHIFT;

    localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = 9'd20;
    localparam logic [STEP_W-1:0]    STEP_SIZE_RST = 16'd16777;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAP_COUNT = 1'b0,
        REG_STEP_SIZE = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic hist_load;
        logic clear;
        logic issue;
        logic upd;
        logic est_load;
        logic err_load;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- sv/lms_anc_ram.sv -----
`default_nettype none

module lms_anc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/lms_anc_ctrl.sv -----
`default_nettype none

module lms_anc_ctrl #(
    parameter int MAX_TAPS = 256,
    localparam int AW = $clog2(MAX_TAPS),
    localparam int CW = $clog2(MAX_TAPS + 1)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_last,
    output logic                         o_in_ready,
    input  wire logic [CW-1:0]           i_taps,
    input  wire lms_anc_pkg::t_dp_status i_status,
    output lms_anc_pkg::t_dp_cmd         o_cmd,
    output logic      [AW-1:0]           o_waddr,
    output logic      [AW-1:0]           o_hist_raddr,
    output logic      [AW-1:0]           o_wt_raddr
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_MAC_WAIT,
        ST_EST,
        ST_ERR,
        ST_OUT,
        ST_UPD,
        ST_UPD_WAIT
    } t_state;

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_k, n_k;
    logic          r_last, n_last;

    logic [AW-1:0] head_nx;
    logic [AW-1:0] rd_dec;
    logic          k_last;
    t_state        done_state;

    assign head_nx    = (r_head == LAST_ADDR) ? '0 : r_head + 1'b1;
    assign rd_dec     = (r_rd == '0) ? LAST_ADDR : r_rd - 1'b1;
    assign k_last     = (CW'(r_k + 1'b1) == i_taps);
    assign done_state = r_last ? ST_CLEAR : ST_IDLE;

    assign o_hist_raddr = r_rd;
    assign o_wt_raddr   = r_k[AW-1:0];

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_rd       = r_rd;
        n_k        = r_k;
        n_last     = r_last;
        o_cmd      = '0;
        o_waddr    = r_rd;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (r_rd == LAST_ADDR) begin
                    n_rd    = '0;
                    n_head  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_rd = r_rd + 1'b1;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_waddr    = head_nx;
                if (i_in_valid) begin
                    o_cmd.hist_load = 1'b1;
                    n_head  = head_nx;
                    n_rd    = head_nx;
                    n_k     = '0;
                    n_last  = i_in_last;
                    n_state = (i_taps == '0) ? ST_EST : ST_MAC;
                end
            end
            ST_MAC: begin
                o_cmd.issue = 1'b1;
                n_k  = r_k + 1'b1;
                n_rd = rd_dec;
                if (k_last) begin
                    n_state = ST_MAC_WAIT;
                end
            end
            ST_MAC_WAIT: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_EST;
                end
            end
            ST_EST: begin
                o_cmd.est_load = 1'b1;
                n_state = ST_ERR;
            end
            ST_ERR: begin
                o_cmd.err_load = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_k = '0;
                    if (i_taps == '0) begin
                        n_rd    = '0;
                        n_state = done_state;
                    end else begin
                        n_rd    = r_head;
                        n_state = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                o_cmd.issue = 1'b1;
                o_cmd.upd   = 1'b1;
                n_k  = r_k + 1'b1;
                n_rd = rd_dec;
                if (k_last) begin
                    n_state = ST_UPD_WAIT;
                end
            end
            ST_UPD_WAIT: begin
                if (!i_status.pipe_busy) begin
                    n_rd    = '0;
                    n_state = done_state;
                end
            end
            default: begin
                n_rd    = '0;
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_head  <= '0;
            r_rd    <= '0;
            r_k     <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_rd    <= n_rd;
            r_k     <= n_k;
            r_last  <= n_last;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lms_anc_dp.sv -----
`default_nettype none

module lms_anc_dp #(
    parameter int MAX_TAPS = 256,
    localparam int AW = $clog2(MAX_TAPS)
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire lms_anc_pkg::t_dp_cmd                     i_cmd,
    output lms_anc_pkg::t_dp_status                       o_status,
    input  wire logic        [AW-1:0]                     i_waddr,
    input  wire logic        [AW-1:0]                     i_hist_raddr,
    input  wire logic        [AW-1:0]                     i_wt_raddr,
    input  wire logic signed [lms_anc_pkg::DATA_W-1:0]    i_ref_sample,
    input  wire logic signed [lms_anc_pkg::DATA_W-1:0]    i_desired_sample,
    input  wire logic        [lms_anc_pkg::STEP_W-1:0]    i_step_size,
    input  wire logic                                     i_out_ready,
    output logic                                          o_out_valid,
    output logic signed      [lms_anc_pkg::DATA_W-1:0]    o_error_sample
);

    localparam int DATA_W  = lms_anc_pkg::DATA_W;
    localparam int WT_W    = lms_anc_pkg::WT_W;
    localparam int MPROD_W = lms_anc_pkg::MPROD_W;
    localparam int MU_E_W  = lms_anc_pkg::MU_E_W;
    localparam int UPROD_W = lms_anc_pkg::UPROD_W;
    localparam int DELTA_W = lms_anc_pkg::DELTA_W;
    localparam int ACC_W   = MPROD_W + AW;
    localparam int EW      = ACC_W - lms_anc_pkg::EST_SHIFT;
    localparam int DW      = EW + 1;

    localparam logic [ACC_W-1:0]   EST_RND = ACC_W'(1) << (lms_anc_pkg::EST_SHIFT - 1);
    localparam logic [UPROD_W-1:0] UPD_RND = UPROD_W'(1) << (lms_anc_pkg::UPD_SHIFT - 1);

    logic [DATA_W-1:0] hist_rdata;
    logic [WT_W-1:0]   wt_rdata;
    logic              wt_we;
    logic [AW-1:0]     wt_waddr;
    logic [WT_W-1:0]   wt_wdata;

    logic r_v1, r_v2, r_v3;
    logic r_m1, r_m2;
    logic [AW-1:0] r_k1, r_k2, r_k3;

    logic signed [MPROD_W-1:0] r_mprod;
    logic signed [UPROD_W-1:0] r_uprod;
    logic signed [WT_W-1:0]    r_w2, r_w3;
    logic signed [DELTA_W-1:0] r_delta;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [EW-1:0]      r_est;
    logic signed [DATA_W-1:0]  r_d;
    logic signed [DATA_W-1:0]  r_err;
    logic signed [MU_E_W-1:0]  r_mu_e;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_out_data;

    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [DW-1:0]      diff;
    logic signed [DATA_W-1:0]  err_sat;
    logic signed [UPROD_W-1:0] upd_rnd;
    logic signed [WT_W:0]      wsum;
    logic signed [WT_W-1:0]    w_sat;

    lms_anc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clear | i_cmd.hist_load),
        .i_waddr (i_waddr),
        .i_wdata (i_cmd.clear ? '0 : i_ref_sample),
        .i_raddr (i_hist_raddr),
        .o_rdata (hist_rdata)
    );

    lms_anc_ram #(
        .WIDTH (WT_W),
        .DEPTH (MAX_TAPS)
    ) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_waddr),
        .i_wdata (wt_wdata),
        .i_raddr (i_wt_raddr),
        .o_rdata (wt_rdata)
    );

    assign wt_we    = i_cmd.clear | r_v3;
    assign wt_waddr = i_cmd.clear ? i_waddr : r_k3;
    assign wt_wdata = i_cmd.clear ? '0 : w_sat;

    // estimate rounding and error saturation
    assign acc_rnd = r_acc + EST_RND;
    assign diff    = {{(DW - DATA_W){r_d[DATA_W-1]}}, r_d} - {r_est[EW-1], r_est};

    always_comb begin
        if (!diff[DW-1] && (|diff[DW-2:DATA_W-1])) begin
            err_sat = {1'b0, {(DATA_W - 1){1'b1}}};
        end else if (diff[DW-1] && !(&diff[DW-2:DATA_W-1])) begin
            err_sat = {1'b1, {(DATA_W - 1){1'b0}}};
        end else begin
            err_sat = diff[DATA_W-1:0];
        end
    end

    // weight update rounding and saturation
    assign upd_rnd = r_uprod + UPD_RND;
    assign wsum    = {r_w3[WT_W-1], r_w3} + {{(WT_W + 1 - DELTA_W){r_delta[DELTA_W-1]}}, r_delta};

    always_comb begin
        if (wsum[WT_W] != wsum[WT_W-1]) begin
            w_sat = wsum[WT_W] ? {1'b1, {(WT_W - 1){1'b0}}} : {1'b0, {(WT_W - 1){1'b1}}};
        end else begin
            w_sat = wsum[WT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2 & r_m2;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1    <= i_cmd.upd;
        r_m2    <= r_m1;
        r_k1    <= i_wt_raddr;
        r_k2    <= r_k1;
        r_k3    <= r_k2;
        r_mprod <= $signed(wt_rdata) * $signed(hist_rdata);
        r_uprod <= r_mu_e * $signed(hist_rdata);
        r_w2    <= wt_rdata;
        r_w3    <= r_w2;
        r_delta <= upd_rnd[UPROD_W-1:lms_anc_pkg::UPD_SHIFT];
        if (i_cmd.hist_load) begin
            r_d   <= i_desired_sample;
            r_acc <= '0;
        end else if (r_v2 && !r_m2) begin
            r_acc <= r_acc + {{AW{r_mprod[MPROD_W-1]}}, r_mprod};
        end
        if (i_cmd.est_load) begin
            r_est <= acc_rnd[ACC_W-1:lms_anc_pkg::EST_SHIFT];
        end
        if (i_cmd.err_load) begin
            r_err <= err_sat;
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_err;
            r_mu_e     <= $signed({1'b0, i_step_size}) * r_err;
        end
    end

    assign o_status.pipe_busy = r_v1 | r_v2 | r_v3;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_error_sample     = r_out_data;

endmodule

`default_nettype wire

// ----- sv/lms_adaptive_noise_canceller.sv -----
// LMS adaptive noise canceller.
// Input stream (s_axis): one transaction carries a reference noise sample and
// a desired sample; tlast marks the end of a signal. Output stream (m_axis):
// one error sample (desired minus filter estimate) per input transaction.
// Config port: i_cfg_we writes i_cfg_wdata to register i_cfg_index
// (0 = tap count, 1 = step size); write only while the block is idle.
// One transaction at a time goes through a shared multiply-accumulate
// pipeline: a filter pass of one tap per cycle, then a weight update pass of
// one tap per cycle (weight RAM read and write each cycle).
// After input accept, the filter pass drains, then the estimate and the error
// are registered and the error is loaded into the output register; input is
// taken again once the weight update pass has drained (zero taps: no passes).
// Reset and every tlast transaction start a clearing sweep of all MAX_TAPS
// entries that zeros history and weights; s_axis_tready stays low during it.
// The result sits in an output register: a stalled receiver does not block the
// next input, but the following result waits until the register frees up.
`default_nettype none

module lms_adaptive_noise_canceller #(
    parameter int MAX_TAPS = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [15:0] ref_sample, [31:16] desired_sample
    input  wire logic        s_axis_tlast,  // last_sample
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,  // [15:0] error_sample
    input  wire logic        i_cfg_we,
    input  wire logic [lms_anc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lms_anc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int AW = $clog2(MAX_TAPS);
    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam int TW = (CW > lms_anc_pkg::TAP_CNT_W) ? CW : lms_anc_pkg::TAP_CNT_W;

    logic [lms_anc_pkg::TAP_CNT_W-1:0] r_tap_count;
    logic [lms_anc_pkg::STEP_W-1:0]    r_step_size;

    logic [TW-1:0]           tap_ext;
    logic [CW-1:0]           taps;
    lms_anc_pkg::t_dp_cmd    cmd;
    lms_anc_pkg::t_dp_status status;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           hist_raddr;
    logic [AW-1:0]           wt_raddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= lms_anc_pkg::TAP_COUNT_RST;
            r_step_size <= lms_anc_pkg::STEP_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lms_anc_pkg::REG_TAP_COUNT: begin
                    r_tap_count <= i_cfg_wdata[lms_anc_pkg::TAP_CNT_W-1:0];
                end
                lms_anc_pkg::REG_STEP_SIZE: begin
                    r_step_size <= i_cfg_wdata[lms_anc_pkg::STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign tap_ext = TW'(r_tap_count);
    assign taps    = (tap_ext > TW'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(tap_ext);

    lms_anc_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_last    (s_axis_tlast),
        .o_in_ready   (s_axis_tready),
        .i_taps       (taps),
        .i_status     (status),
        .o_cmd        (cmd),
        .o_waddr      (waddr),
        .o_hist_raddr (hist_raddr),
        .o_wt_raddr   (wt_raddr)
    );

    lms_anc_dp #(
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_waddr          (waddr),
        .i_hist_raddr     (hist_raddr),
        .i_wt_raddr       (wt_raddr),
        .i_ref_sample     (s_axis_tdata[15:0]),
        .i_desired_sample (s_axis_tdata[31:16]),
        .i_step_size      (r_step_size),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_error_sample   (m_axis_tdata)
    );

    a_ready_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !status.pipe_busy)
        else $error("input ready while MAC pipeline busy");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second transaction accepted while one in flight");

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> !s_axis_tready && !cmd.issue)
        else $error("activity during clearing sweep");

endmodule

`default_nettype wire
